FILE: rtl/core/dcrd_pkg.sv
package dcrd_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned IntBytesW = 3;
	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned QueueDepth = 4;

	localparam logic [IntBytesW-1:0] IntBytesReset = 3'd4;

	localparam logic [CfgIndexW-1:0] CfgIntBytes = 2'd0;
	localparam logic [CfgIndexW-1:0] CfgAddBlockStart = 2'd1;
	localparam logic [CfgIndexW-1:0] CfgTargetSize = 2'd2;

	localparam logic FuncRecord = 1'b0;
	localparam logic FuncFinish = 1'b1;

	localparam logic KindAdd = 1'b0;
	localparam logic KindCopy = 1'b1;

	// Record as classified by the front part.
	typedef struct packed {
		logic             finish;
		logic             has_add;
		logic             has_copy;
		logic [WordW-1:0] rel_ext;
		logic [WordW-1:0] insert_len;
		logic [WordW-1:0] source_len;
	} rec_t;

	typedef enum logic {
		PH_FIRST,
		PH_SECOND
	} phase_t;

endpackage

FILE: rtl/core/delta_control_record_decoder.sv
// Decodes delta patch control records into add and copy commands. An input
// transfer is taken in any cycle while the record queue has room. The back
// end retires one record per cycle while the output is not stalled; a record
// with both a nonzero add and a nonzero copy length sends its add and then its
// copy command through the single output register, which sets the sustained
// rate. Each record waits in the record queue, then its commands in the output
// register. Configuration is written through cfg_we, cfg_index and cfg_data
// and must only change while the block is idle.
module delta_control_record_decoder #(
	parameter int unsigned QUEUE_DEPTH = dcrd_pkg::QueueDepth
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dcrd_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [dcrd_pkg::WordW-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [dcrd_pkg::WordW-1:0]     rel_offset,
	input  logic [dcrd_pkg::WordW-1:0]     insert_len,
	input  logic [dcrd_pkg::WordW-1:0]     source_len,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           cmd_kind,
	output logic [dcrd_pkg::WordW-1:0]     cmd_pos,
	output logic [dcrd_pkg::WordW-1:0]     cmd_len,
	output logic                           last
);

	logic [dcrd_pkg::IntBytesW-1:0] int_bytes_q;
	logic [dcrd_pkg::WordW-1:0]     add_block_start_q;
	logic [dcrd_pkg::WordW-1:0]     target_size_q;

	dcrd_pkg::rec_t front_rec;
	dcrd_pkg::rec_t head_rec;
	logic           full;
	logic           head_valid;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_bytes_q       <= dcrd_pkg::IntBytesReset;
			add_block_start_q <= '0;
			target_size_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dcrd_pkg::CfgIntBytes: int_bytes_q <= cfg_data[dcrd_pkg::IntBytesW-1:0];
				dcrd_pkg::CfgAddBlockStart: add_block_start_q <= cfg_data;
				dcrd_pkg::CfgTargetSize: target_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dcrd_front u_front (
		.func       (func),
		.rel_offset (rel_offset),
		.insert_len (insert_len),
		.source_len (source_len),
		.int_bytes  (int_bytes_q),
		.rec        (front_rec)
	);

	dcrd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid),
		.push_rec   (front_rec),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	assign in_stall = full;

	dcrd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_rec        (head_rec),
		.pop             (pop),
		.add_block_start (add_block_start_q),
		.target_size     (target_size_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cmd_kind        (cmd_kind),
		.cmd_pos         (cmd_pos),
		.cmd_len         (cmd_len),
		.last            (last)
	);

endmodule

FILE: rtl/core/dcrd_front.sv
module dcrd_front (
	input  logic                                func,
	input  logic [dcrd_pkg::WordW-1:0]          rel_offset,
	input  logic [dcrd_pkg::WordW-1:0]          insert_len,
	input  logic [dcrd_pkg::WordW-1:0]          source_len,
	input  logic [dcrd_pkg::IntBytesW-1:0]      int_bytes,
	output dcrd_pkg::rec_t                      rec
);

	logic [dcrd_pkg::WordW-1:0] rel_ext;

	// Widths below one byte act as one byte, widths above four act as four.
	always_comb begin
		unique case (int_bytes)
			3'd0, 3'd1: rel_ext = {{24{rel_offset[7]}}, rel_offset[7:0]};
			3'd2: rel_ext = {{16{rel_offset[15]}}, rel_offset[15:0]};
			3'd3: rel_ext = {{8{rel_offset[23]}}, rel_offset[23:0]};
			default: rel_ext = rel_offset;
		endcase
	end

	always_comb begin
		rec.finish     = (func == dcrd_pkg::FuncFinish);
		rec.has_add    = (insert_len != '0);
		rec.has_copy   = (source_len != '0);
		rec.rel_ext    = rel_ext;
		rec.insert_len = insert_len;
		rec.source_len = source_len;
	end

endmodule

FILE: rtl/core/dcrd_queue.sv
module dcrd_queue #(
	parameter int unsigned DEPTH = dcrd_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dcrd_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output dcrd_pkg::rec_t head_rec
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	dcrd_pkg::rec_t entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_rec   = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/dcrd_back.sv
module dcrd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  dcrd_pkg::rec_t             head_rec,
	output logic                       pop,
	input  logic [dcrd_pkg::WordW-1:0] add_block_start,
	input  logic [dcrd_pkg::WordW-1:0] target_size,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       cmd_kind,
	output logic [dcrd_pkg::WordW-1:0] cmd_pos,
	output logic [dcrd_pkg::WordW-1:0] cmd_len,
	output logic                       last
);

	dcrd_pkg::phase_t phase_q;
	dcrd_pkg::phase_t phase_d;

	logic [dcrd_pkg::WordW-1:0] source_pos_q;
	logic [dcrd_pkg::WordW-1:0] add_offset_q;
	logic [dcrd_pkg::WordW-1:0] produced_q;
	logic [dcrd_pkg::WordW-1:0] source_pos_d;
	logic [dcrd_pkg::WordW-1:0] add_offset_d;
	logic [dcrd_pkg::WordW-1:0] produced_d;

	logic                       out_valid_q;
	logic                       kind_q;
	logic [dcrd_pkg::WordW-1:0] pos_q;
	logic [dcrd_pkg::WordW-1:0] len_q;
	logic                       last_q;

	logic                       out_ok;
	logic                       go;
	logic                       emit;
	logic                       emit_kind;
	logic [dcrd_pkg::WordW-1:0] emit_pos;
	logic [dcrd_pkg::WordW-1:0] emit_len;
	logic                       emit_last;
	logic [dcrd_pkg::WordW-1:0] copy_pos;

	// The output register can take a new command when empty or when its
	// current command transfers at this edge.
	assign out_ok   = !out_valid_q || !out_stall;
	assign go       = head_valid && out_ok;
	assign copy_pos = source_pos_q + head_rec.rel_ext;

	always_comb begin
		phase_d = phase_q;
		if (go && !head_rec.finish) begin
			unique case (phase_q)
				dcrd_pkg::PH_FIRST: begin
					if (head_rec.has_add && head_rec.has_copy) begin
						phase_d = dcrd_pkg::PH_SECOND;
					end
				end
				dcrd_pkg::PH_SECOND: phase_d = dcrd_pkg::PH_FIRST;
				default: phase_d = dcrd_pkg::PH_FIRST;
			endcase
		end
	end

	always_comb begin
		pop          = 1'b0;
		emit         = 1'b0;
		emit_kind    = dcrd_pkg::KindAdd;
		emit_pos     = add_block_start + add_offset_q;
		emit_len     = head_rec.insert_len;
		emit_last    = 1'b1;
		source_pos_d = source_pos_q;
		add_offset_d = add_offset_q;
		produced_d   = produced_q;
		if (go) begin
			if (head_rec.finish) begin
				pop          = 1'b1;
				emit         = (produced_q < target_size);
				emit_len     = target_size - produced_q;
				source_pos_d = '0;
				add_offset_d = '0;
				produced_d   = '0;
			end else if (phase_q == dcrd_pkg::PH_FIRST && head_rec.has_add) begin
				emit         = 1'b1;
				emit_last    = !head_rec.has_copy;
				add_offset_d = add_offset_q + head_rec.insert_len;
				if (!head_rec.has_copy) begin
					pop          = 1'b1;
					source_pos_d = copy_pos;
					produced_d   = produced_q + head_rec.insert_len;
				end
			end else begin
				// Copy half of the record; the offset moves the source even
				// when nothing is copied.
				pop          = 1'b1;
				emit         = head_rec.has_copy;
				emit_kind    = dcrd_pkg::KindCopy;
				emit_pos     = copy_pos;
				emit_len     = head_rec.source_len;
				source_pos_d = copy_pos + head_rec.source_len;
				produced_d   = produced_q + head_rec.insert_len + head_rec.source_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= dcrd_pkg::PH_FIRST;
			source_pos_q <= '0;
			add_offset_q <= '0;
			produced_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			source_pos_q <= source_pos_d;
			add_offset_q <= add_offset_d;
			produced_q   <= produced_d;
			if (out_ok) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ok && emit) begin
			kind_q <= emit_kind;
			pos_q  <= emit_pos;
			len_q  <= emit_len;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign cmd_kind  = kind_q;
	assign cmd_pos   = pos_q;
	assign cmd_len   = len_q;
	assign last      = last_q;

endmodule

FILE: rtl/core/dcrd_checker.sv
module dcrd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       cmd_kind,
	input logic [dcrd_pkg::WordW-1:0] cmd_pos,
	input logic [dcrd_pkg::WordW-1:0] cmd_len,
	input logic                       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled output command was dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cmd_kind) && $stable(cmd_pos)
			&& $stable(cmd_len) && $stable(last))
		else $error("stalled output command changed");

	// A copy always closes its record.
	a_copy_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_kind == dcrd_pkg::KindCopy |-> last)
		else $error("copy command without last");

	// An add that does not close its record is followed at once by its copy.
	a_add_then_copy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && cmd_kind == dcrd_pkg::KindCopy)
		else $error("open add command not followed by its copy");

endmodule

bind delta_control_record_decoder dcrd_checker u_dcrd_checker (.*);
